@@ hdl/sbuh_pkg.sv @@
// Shared types and constants for the sample bit-usage histogram unit.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package sbuh_pkg;

   // Field widths of the item ports.
   localparam int BEAM_BITS   = 8;
   localparam int SAMPLE_BITS = 16;
   localparam int INDEX_BITS  = 5;
   localparam int VALUE_BITS  = 32;
   localparam int CFG_BITS    = 9;

   // Reset value of the active beamlet count.
   localparam logic [CFG_BITS-1:0] ACTIVE_RESET = 9'd256;

   // Counter layout of one beamlet row.
   localparam int SLOTS        = 16;
   localparam int MAG_COUNTERS = 15;
   localparam int NEG_SLOT     = 15;
   localparam int DUMP_COUNT   = 17;
   localparam logic [INDEX_BITS-1:0] TOTAL_INDEX = 5'd16;

   // Item kinds.
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_DUMP   = 1'b1;

   // One operation handed from the front end to the counter store.
   typedef struct packed {
      logic                    valid;
      logic                    dump;
      logic                    have;
      logic                    neg;
      logic [MAG_COUNTERS-1:0] mag_mask;
   } sbuh_op_type;

   // Store status seen by the front end.
   typedef struct packed {
      logic clearing;
      logic row_valid;
   } sbuh_status_type;

   // Address width for a memory of the given depth.
   function automatic int addr_bits(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

endpackage

`default_nettype wire

@@ hdl/sbuh_bitcount.sv @@
// Sample magnitude and bit-usage mask for the histogram unit.
// Depends on sbuh_pkg.
`default_nettype none

module sbuh_bitcount (
   input  logic signed [sbuh_pkg::SAMPLE_BITS-1:0]  sample,
   output logic                                     neg,
   output logic        [sbuh_pkg::MAG_COUNTERS-1:0] mag_mask
);
   import sbuh_pkg::*;

   logic [SAMPLE_BITS-1:0] mag_w;
   logic [3:0]             top_w;

   // Magnitude; the most negative sample maps to 0x8000.
   assign neg   = sample[SAMPLE_BITS-1];
   assign mag_w = neg ? (~$unsigned(sample) + 16'd1) : $unsigned(sample);

   // Highest set bit among bits 1 to 15; a magnitude of one counts as one bit.
   always_comb begin
      top_w = 4'(mag_w[0]);
      for (int pos = 1; pos < SAMPLE_BITS; pos++) begin
         if (mag_w[pos]) begin
            top_w = 4'(pos);
         end
      end
   end

   // Counters below the bit count are incremented.
   always_comb begin
      for (int k = 0; k < MAG_COUNTERS; k++) begin
         mag_mask[k] = (4'(k) < top_w);
      end
   end

endmodule

`default_nettype wire

@@ hdl/sbuh_store.sv @@
// Counter memories with read-modify-write, forwarding and the clearing pass.
// Depends on sbuh_pkg.
`default_nettype none

module sbuh_store #(
   parameter int MAX_BEAMLETS = 256,
   parameter int COUNTER_BITS = 32
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  sbuh_pkg::sbuh_op_type                          op,
   input  logic [sbuh_pkg::addr_bits(MAX_BEAMLETS)-1:0]   addr,
   output sbuh_pkg::sbuh_status_type                      status,
   output logic [sbuh_pkg::SLOTS-1:0][COUNTER_BITS-1:0]   dump_row,
   output logic [COUNTER_BITS-1:0]                        dump_total
);
   import sbuh_pkg::*;

   localparam int ROW_AW = addr_bits(MAX_BEAMLETS);
   localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(MAX_BEAMLETS - 1);

   typedef logic [SLOTS-1:0][COUNTER_BITS-1:0] row_type;
   typedef logic [COUNTER_BITS-1:0]            count_type;

   row_type     bit_mem [MAX_BEAMLETS];
   count_type   tot_mem [MAX_BEAMLETS];

   row_type     bit_rd_ff;
   count_type   tot_rd_ff;
   sbuh_op_type s1_op_ff;
   logic [ROW_AW-1:0] s1_addr_ff;

   logic        fwd_valid_ff;
   logic [ROW_AW-1:0] fwd_addr_ff;
   row_type     fwd_row_ff;
   count_type   fwd_tot_ff;

   logic        clr_active_ff;
   logic [ROW_AW-1:0] clr_addr_ff;

   logic        fwd_hit;
   logic        wr_accum;
   row_type     cur_row;
   count_type   cur_tot;
   row_type     row_in;
   count_type   tot_in;

   // Saturating increment of one counter.
   function automatic count_type sat_inc(input count_type c);
      return (&c) ? c : c + COUNTER_BITS'(1);
   endfunction

   // The row written at the previous edge is not yet visible in the read data.
   assign fwd_hit  = fwd_valid_ff && (fwd_addr_ff == s1_addr_ff);
   assign cur_row  = fwd_hit ? fwd_row_ff : bit_rd_ff;
   assign cur_tot  = fwd_hit ? fwd_tot_ff : tot_rd_ff;
   assign wr_accum = s1_op_ff.valid && !s1_op_ff.dump;

   // Updated counters of the sample in the second stage.
   always_comb begin
      for (int k = 0; k < MAG_COUNTERS; k++) begin
         row_in[k] = s1_op_ff.mag_mask[k] ? sat_inc(cur_row[k]) : cur_row[k];
      end
      row_in[NEG_SLOT] = s1_op_ff.neg ? sat_inc(cur_row[NEG_SLOT]) : cur_row[NEG_SLOT];
      tot_in = sat_inc(cur_tot);
   end

   // A beamlet without storage dumps zeros.
   assign dump_row         = s1_op_ff.have ? cur_row : '0;
   assign dump_total       = s1_op_ff.have ? cur_tot : '0;
   assign status.clearing  = clr_active_ff;
   assign status.row_valid = s1_op_ff.valid && s1_op_ff.dump;

   // Memories: one row write and one row read per cycle.
   always_ff @(posedge clock) begin
      if (clr_active_ff) begin
         bit_mem[clr_addr_ff] <= '0;
         tot_mem[clr_addr_ff] <= '0;
      end else if (wr_accum) begin
         bit_mem[s1_addr_ff] <= row_in;
         tot_mem[s1_addr_ff] <= tot_in;
      end
      if (op.valid && op.have) begin
         bit_rd_ff <= bit_mem[addr];
         tot_rd_ff <= tot_mem[addr];
      end
   end

   // Second stage and forwarding registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_op_ff.valid <= 1'b0;
         fwd_valid_ff   <= 1'b0;
      end else begin
         s1_op_ff     <= op;
         fwd_valid_ff <= wr_accum;
      end
      s1_addr_ff  <= addr;
      fwd_addr_ff <= s1_addr_ff;
      fwd_row_ff  <= row_in;
      fwd_tot_ff  <= tot_in;
   end

   // Clearing pass after reset, one row per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else if (clr_active_ff) begin
         if (clr_addr_ff == LAST_ROW) begin
            clr_active_ff <= 1'b0;
         end else begin
            clr_addr_ff <= clr_addr_ff + ROW_AW'(1);
         end
      end
   end

endmodule

`default_nettype wire

@@ hdl/sample_bit_usage_histogram_unit.sv @@
// Top level of the sample bit-usage histogram unit: item handshake, config
// register and dump sequencer. Depends on sbuh_pkg, sbuh_bitcount, sbuh_store.
//
// Usage:
//  An item is taken at a clock edge where start is high and busy is low.
//  A sample item (kind 0) updates the counters of its beamlet and gives no
//  result; samples are taken one per cycle, back to back, while busy is low.
//  A sample whose beamlet is not below the active count (or the storage
//  depth) is dropped. A dump item (kind 1) gives 17 results, counter index
//  0 to 16, one per cycle on rsp_valid, with rsp_last on index 16. The first
//  result follows the row read in the store and the load of the dump row;
//  busy stays high through the row read and the output sequencer. Counters
//  sit as one row per beamlet in a memory read in the cycle before the write
//  back; a row written in the cycle of a read is forwarded. The receiver
//  cannot stall: each result is valid for one cycle only. After reset every
//  row is cleared, one row per cycle, and busy stays high until the last
//  row is cleared. The csr channel is always ready; the user must see that
//  it is written only while the unit is idle; the unit does not enforce it.
`default_nettype none

module sample_bit_usage_histogram_unit #(
   parameter int MAX_BEAMLETS = 256,
   parameter int COUNTER_BITS = 32
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   output logic                                     busy,
   input  logic                                     req_kind,
   input  logic        [sbuh_pkg::BEAM_BITS-1:0]    req_beamlet,
   input  logic signed [sbuh_pkg::SAMPLE_BITS-1:0]  req_sample,
   output logic                                     rsp_valid,
   output logic        [sbuh_pkg::INDEX_BITS-1:0]   rsp_counter_index,
   output logic        [sbuh_pkg::VALUE_BITS-1:0]   rsp_counter_value,
   output logic                                     rsp_last,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic        [sbuh_pkg::CFG_BITS-1:0]     csr_data
);
   import sbuh_pkg::*;

   localparam int ROW_AW = addr_bits(MAX_BEAMLETS);

   typedef logic [COUNTER_BITS-1:0] count_type;

   sbuh_op_type     op;
   sbuh_status_type status;
   logic [ROW_AW-1:0] addr;
   logic [SLOTS-1:0][COUNTER_BITS-1:0] dump_row;
   count_type       dump_total;

   logic            accept;
   logic            have;
   logic            active_hit;
   logic            neg_w;
   logic [MAG_COUNTERS-1:0] mask_w;

   logic [CFG_BITS-1:0]   active_ff;
   logic                  emit_active_ff;
   logic [INDEX_BITS-1:0] emit_idx_ff;
   count_type             dump_cnt_ff [DUMP_COUNT];

   logic                  rsp_valid_ff;
   logic [INDEX_BITS-1:0] rsp_index_ff;
   logic [VALUE_BITS-1:0] rsp_value_ff;
   logic                  rsp_last_ff;
   logic [VALUE_BITS-1:0] rsp_value_in;

   // Handshake.
   assign busy      = status.clearing || status.row_valid || emit_active_ff;
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   // Beamlet checks against storage depth and the active count.
   assign have       = int'(req_beamlet) < MAX_BEAMLETS;
   assign active_hit = CFG_BITS'(req_beamlet) < active_ff;
   assign addr       = ROW_AW'(req_beamlet);

   sbuh_bitcount u_bitcount (
      .sample   (req_sample),
      .neg      (neg_w),
      .mag_mask (mask_w)
   );

   // Operation for the store; dropped samples never reach it.
   always_comb begin
      op.dump     = (req_kind == KIND_DUMP);
      op.valid    = accept && (op.dump || (have && active_hit));
      op.have     = have;
      op.neg      = neg_w;
      op.mag_mask = mask_w;
   end

   sbuh_store #(
      .MAX_BEAMLETS (MAX_BEAMLETS),
      .COUNTER_BITS (COUNTER_BITS)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .op         (op),
      .addr       (addr),
      .status     (status),
      .dump_row   (dump_row),
      .dump_total (dump_total)
   );

   // Reported value is clipped to 32 bits for wide counters.
   if (COUNTER_BITS > VALUE_BITS) begin : g_clip
      assign rsp_value_in = (|dump_cnt_ff[0][COUNTER_BITS-1:VALUE_BITS]) ?
                            '1 : dump_cnt_ff[0][VALUE_BITS-1:0];
   end else begin : g_extend
      assign rsp_value_in = VALUE_BITS'(dump_cnt_ff[0]);
   end

   // Dump row: loaded once, then shifted out one counter per cycle.
   always_ff @(posedge clock) begin
      if (status.row_valid) begin
         for (int k = 0; k < SLOTS; k++) begin
            dump_cnt_ff[k] <= dump_row[k];
         end
         dump_cnt_ff[TOTAL_INDEX] <= dump_total;
      end else if (emit_active_ff) begin
         for (int k = 0; k < DUMP_COUNT - 1; k++) begin
            dump_cnt_ff[k] <= dump_cnt_ff[k + 1];
         end
      end
   end

   // Config register and dump sequencer control.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff      <= ACTIVE_RESET;
         emit_active_ff <= 1'b0;
         emit_idx_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            active_ff <= csr_data;
         end
         rsp_valid_ff <= emit_active_ff;
         if (status.row_valid) begin
            emit_active_ff <= 1'b1;
            emit_idx_ff    <= '0;
         end else if (emit_active_ff) begin
            emit_idx_ff <= emit_idx_ff + INDEX_BITS'(1);
            if (emit_idx_ff == TOTAL_INDEX) begin
               emit_active_ff <= 1'b0;
            end
         end
      end
   end

   // Result payload registers.
   always_ff @(posedge clock) begin
      if (emit_active_ff) begin
         rsp_index_ff <= emit_idx_ff;
         rsp_value_ff <= rsp_value_in;
         rsp_last_ff  <= (emit_idx_ff == TOTAL_INDEX);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_counter_index = rsp_index_ff;
   assign rsp_counter_value = rsp_value_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

`default_nettype wire

@@ hdl/sbuh_checker.sv @@
// Port-level checks of the histogram unit's dump sequence and reset behavior.
// Depends on sbuh_pkg; bound to sample_bit_usage_histogram_unit.
`default_nettype none

module sbuh_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  start,
   input logic                                  busy,
   input logic                                  req_kind,
   input logic                                  rsp_valid,
   input logic [sbuh_pkg::INDEX_BITS-1:0]       rsp_counter_index,
   input logic                                  rsp_last
);
   import sbuh_pkg::*;

   // The clearing pass holds off items right after reset.
   a_clear_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> busy)
      else $error("unit not busy after reset");

   // A taken dump blocks further items in the next cycle.
   a_dump_blocks: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_kind == KIND_DUMP) |=> busy)
      else $error("unit not busy after a dump item");

   // Results of a dump come in consecutive cycles with rising index.
   a_dump_sequence: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |=>
         (rsp_valid && rsp_counter_index == $past(rsp_counter_index) + 5'd1))
      else $error("dump results not contiguous");

   // The last flag marks the total counter only.
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_counter_index == TOTAL_INDEX)))
      else $error("last flag on wrong counter");

   // A dump starts at index zero after a gap.
   a_dump_start: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_counter_index == 5'd0) |-> !$past(rsp_valid))
      else $error("dump started without a gap");

endmodule

bind sample_bit_usage_histogram_unit sbuh_checker u_sbuh_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .req_kind          (req_kind),
   .rsp_valid         (rsp_valid),
   .rsp_counter_index (rsp_counter_index),
   .rsp_last          (rsp_last)
);

`default_nettype wire

@@ sim/testbench.sv @@
// Self-checking testbench for sample_bit_usage_histogram_unit.
// Depends on sbuh_pkg and the unit's RTL; predicts dump contents in place and
// checks every counter result against the prediction.
`timescale 1ns / 1ps

module testbench;
   import sbuh_pkg::*;

   localparam int NUM_BEAMS     = 256;
   localparam int WATCHDOG_MAX  = 3000;
   localparam int SETTLE_CYCLES = 24;
   localparam int RANDOM_PHASE  = 50;
   localparam int REPORT_MAX    = 10;

   typedef struct {
      logic                          kind;
      logic [BEAM_BITS-1:0]          beamlet;
      logic signed [SAMPLE_BITS-1:0] sample;
   } hist_item_type;

   typedef struct {
      logic [INDEX_BITS-1:0] index;
      logic [VALUE_BITS-1:0] value;
      logic                  is_last;
   } counter_word_type;

   // Block ports.
   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic                          req_kind = 1'b0;
   logic [BEAM_BITS-1:0]          req_beamlet = '0;
   logic signed [SAMPLE_BITS-1:0] req_sample = '0;
   logic                          rsp_valid;
   logic [INDEX_BITS-1:0]         rsp_counter_index;
   logic [VALUE_BITS-1:0]         rsp_counter_value;
   logic                          rsp_last;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [CFG_BITS-1:0]           csr_data = '0;

   // Predicted counter store and active beamlet count.
   logic [VALUE_BITS-1:0] bit_tally [0:NUM_BEAMS-1][0:SLOTS-1];
   logic [VALUE_BITS-1:0] total_tally [0:NUM_BEAMS-1];
   logic [CFG_BITS-1:0]   active_level = ACTIVE_RESET;

   hist_item_type    pending_items [$];
   counter_word_type dump_words [$];
   hist_item_type    driven_item;
   int               queued_count = 0;
   int               accepted_count = 0;
   int               mismatch_count = 0;
   int               burst_left = 0;
   int               gap_left = 0;

   sample_bit_usage_histogram_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_kind          (req_kind),
      .req_beamlet       (req_beamlet),
      .req_sample        (req_sample),
      .rsp_valid         (rsp_valid),
      .rsp_counter_index (rsp_counter_index),
      .rsp_counter_value (rsp_counter_value),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_data          (csr_data)
   );

   always #5 clock = ~clock;

   // Number of low bit counters a magnitude touches.
   function automatic int magnitude_bits(input logic [SAMPLE_BITS:0] mag);
      int h;
      h = (mag != '0) ? 1 : 0;
      for (int pos = 1; pos <= MAG_COUNTERS; pos++) begin
         if (mag[pos]) h = pos;
      end
      return h;
   endfunction

   function automatic logic [VALUE_BITS-1:0] bump(input logic [VALUE_BITS-1:0] count);
      return (count == '1) ? count : count + 1'b1;
   endfunction

   // Update the predicted store for one accepted item, or queue a dump's words.
   function automatic void tally_item(input hist_item_type it);
      logic                  neg;
      logic [SAMPLE_BITS:0]  mag;
      int                    h;
      int                    b;
      counter_word_type      w;
      b = it.beamlet;
      if (it.kind == KIND_SAMPLE) begin
         if ({1'b0, it.beamlet} >= active_level) return;
         neg = it.sample[SAMPLE_BITS-1];
         mag = neg ? (17'h10000 - {1'b0, it.sample}) : {1'b0, it.sample};
         if (neg) bit_tally[b][NEG_SLOT] = bump(bit_tally[b][NEG_SLOT]);
         h = magnitude_bits(mag);
         for (int k = 0; k < h; k++) bit_tally[b][k] = bump(bit_tally[b][k]);
         total_tally[b] = bump(total_tally[b]);
      end else begin
         for (int k = 0; k < DUMP_COUNT; k++) begin
            w.index   = k[INDEX_BITS-1:0];
            w.is_last = (w.index == TOTAL_INDEX);
            w.value   = w.is_last ? total_tally[b] : bit_tally[b][k];
            dump_words.insert(dump_words.size(), w);
         end
      end
   endfunction

   // Length of the next pause between bursts; often none at all.
   function automatic int pick_gap();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 4) return 0;
      if (sel < 8) return $urandom_range(1, 4);
      if (sel < 9) return $urandom_range(5, 12);
      return $urandom_range(13, 20);
   endfunction

   // Driver: presents queued items in random bursts and tallies each accepted one.
   always @(posedge clock) begin
      if (reset) begin
         start      <= 1'b0;
         burst_left = $urandom_range(1, 24);
         gap_left   = 0;
      end else begin
         if (start && !busy) begin
            tally_item(driven_item);
            accepted_count++;
         end
         if (!start || !busy) begin
            if (gap_left > 0 || pending_items.size() == 0) begin
               if (gap_left > 0) gap_left--;
               start <= 1'b0;
            end else begin
               driven_item = pending_items.pop_front();
               req_kind    <= driven_item.kind;
               req_beamlet <= driven_item.beamlet;
               req_sample  <= driven_item.sample;
               start       <= 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = pick_gap();
               end
            end
         end
      end
   end

   // Monitor: every result must match the oldest predicted dump word.
   always @(posedge clock) begin
      counter_word_type w;
      if (!reset && rsp_valid) begin
         if (dump_words.size() == 0) begin
            if (mismatch_count < REPORT_MAX)
               $display("unexpected result: index %0d value %0d last %0b",
                        rsp_counter_index, rsp_counter_value, rsp_last);
            mismatch_count++;
         end else begin
            w = dump_words.pop_front();
            if (rsp_counter_index !== w.index || rsp_counter_value !== w.value ||
                rsp_last !== w.is_last) begin
               if (mismatch_count < REPORT_MAX)
                  $display("result mismatch: index %0d/%0d value %0d/%0d last %0b/%0b (exp/got)",
                           w.index, rsp_counter_index, w.value, rsp_counter_value,
                           w.is_last, rsp_last);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: ends the run when nothing moves for too long.
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_MAX) begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("end of test: mismatches");
      $finish;
   end

   task automatic push_item(input logic kind, input int beam, input int value);
      hist_item_type it;
      it.kind    = kind;
      it.beamlet = beam[BEAM_BITS-1:0];
      it.sample  = value[SAMPLE_BITS-1:0];
      pending_items.insert(pending_items.size(), it);
      queued_count++;
   endtask

   // Random item: samples cluster on a few beamlets and the active boundary.
   task automatic push_random_item();
      logic kind;
      int   beam;
      int   value;
      int   sel;
      kind = ($urandom_range(0, 99) < 15) ? KIND_DUMP : KIND_SAMPLE;
      sel  = $urandom_range(0, 9);
      if (sel < 6)
         beam = $urandom_range(0, 7);
      else if (sel < 8)
         beam = $urandom_range((active_level > 2) ? active_level - 2 : 0,
                               (active_level < 255) ? active_level + 1 : 255);
      else
         beam = $urandom_range(0, 255);
      if (beam > 255) beam = 255;
      case ($urandom_range(0, 5))
         0, 1: value = $urandom;
         2: value = $urandom_range(0, 6) - 3;
         3: value = 1 << $urandom_range(0, 15);
         4: begin
            case ($urandom_range(0, 3))
               0: value = 32767;
               1: value = -32768;
               2: value = -32767;
               default: value = 0;
            endcase
         end
         default: value = ($urandom & 16'hFFFF) >> $urandom_range(1, 15);
      endcase
      if (sel[0]) value = -value;
      push_item(kind, beam, value);
   endtask

   // Wait until all items are taken, all words are back and the unit is idle.
   task automatic drain();
      while (accepted_count != queued_count) @(posedge clock);
      while (dump_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_active(input int value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value[CFG_BITS-1:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid    <= 1'b0;
      active_level = value[CFG_BITS-1:0];
   endtask

   // Stimulus sequence.
   initial begin
      int leftover;
      for (int b = 0; b < NUM_BEAMS; b++) begin
         total_tally[b] = '0;
         for (int k = 0; k < SLOTS; k++) bit_tally[b][k] = '0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Magnitude edges, sign cases and the highest beamlet at the reset count.
      push_item(KIND_SAMPLE, 0, 0);
      push_item(KIND_SAMPLE, 0, 1);
      push_item(KIND_SAMPLE, 0, -1);
      push_item(KIND_SAMPLE, 0, 2);
      push_item(KIND_SAMPLE, 0, 3);
      push_item(KIND_SAMPLE, 0, 32767);
      push_item(KIND_SAMPLE, 0, -32768);
      push_item(KIND_SAMPLE, 0, -32767);
      push_item(KIND_SAMPLE, 0, 16'h4000);
      push_item(KIND_SAMPLE, 255, -2);
      push_item(KIND_SAMPLE, 255, 12345);
      push_item(KIND_DUMP, 0, 0);
      push_item(KIND_DUMP, 255, 16'hFFFF);
      push_item(KIND_DUMP, 77, 0);
      drain();

      // One active beamlet: others are dropped, yet still dump their counters.
      write_active(1);
      push_item(KIND_SAMPLE, 0, -5);
      push_item(KIND_SAMPLE, 1, 100);
      push_item(KIND_SAMPLE, 255, 7);
      push_item(KIND_DUMP, 0, 0);
      push_item(KIND_DUMP, 1, 0);
      drain();

      // A zero count drops every sample; the widest setting acts as all beamlets.
      write_active(0);
      push_item(KIND_SAMPLE, 0, 9);
      push_item(KIND_DUMP, 0, 0);
      drain();
      write_active(511);
      push_item(KIND_SAMPLE, 255, -32768);
      push_item(KIND_DUMP, 255, 0);
      drain();

      // Random phases across a spread of active counts.
      write_active($urandom_range(2, 255));
      repeat (RANDOM_PHASE) push_random_item();
      drain();
      write_active(256);
      repeat (RANDOM_PHASE) push_random_item();
      drain();
      write_active(1);
      repeat (RANDOM_PHASE) push_random_item();
      drain();
      write_active(0);
      repeat (RANDOM_PHASE) push_random_item();
      drain();
      write_active(511);
      repeat (RANDOM_PHASE) push_random_item();
      drain();
      write_active($urandom_range(257, 510));
      repeat (RANDOM_PHASE) push_random_item();
      drain();
      write_active($urandom_range(2, 255));
      repeat (RANDOM_PHASE) push_random_item();
      drain();

      leftover = dump_words.size();
      if (mismatch_count == 0 && leftover == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
